### rtl/core/assert_macros.svh
// Assertion macros shared by the line fit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RLF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rlf_pkg.sv
// Shared types, codes and saturation helper for the line fit block.
package rlf_pkg;

    localparam int WIDE_W = 128;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [63:0]       q64_t;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_EVAL  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

    // Clamp a signed 128-bit value to the signed 64-bit range.
    function automatic q64_t sat64(input wide_t v);
        q64_t r;
        if ((v[127:63] == '0) || (v[127:63] == '1)) begin
            r = v[63:0];
        end else if (v[127]) begin
            r = {1'b1, 63'd0};
        end else begin
            r = {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/core/rlf_muldiv.sv
// Shared iterative unit: signed 64x64 multiply and saturating signed 128/128 divide.
`include "assert_macros.svh"

module rlf_muldiv (
    input  logic            aclk,
    input  logic            aresetn,
    input  rlf_pkg::md_cmd_t cmd,
    input  rlf_pkg::wide_t  op_a,
    input  rlf_pkg::wide_t  op_b,
    output rlf_pkg::md_stat_t stat,
    output rlf_pkg::wide_t  prod,
    output rlf_pkg::q64_t   quot
);
    import rlf_pkg::*;

    logic        busy_reg, done_reg, is_div_reg, neg_reg;
    logic [7:0]  cnt_reg;
    logic [63:0] amag_reg, bmag_reg;
    logic [63:0] pp_reg;
    logic [1:0]  sh_reg;
    logic [127:0] acc_reg, n_reg, d_reg, r_reg, q_reg;
    wide_t       prod_reg;
    q64_t        quot_reg;

    logic [31:0]  a_half, b_half;
    logic [127:0] rsh;
    logic         fits;

    assign a_half = cnt_reg[1] ? amag_reg[63:32] : amag_reg[31:0];
    assign b_half = cnt_reg[0] ? bmag_reg[63:32] : bmag_reg[31:0];
    assign rsh    = {r_reg[126:0], n_reg[127]};
    assign fits   = (rsh >= d_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg   <= 1'b1;
                is_div_reg <= cmd.is_div;
                cnt_reg    <= '0;
                acc_reg    <= '0;
                r_reg      <= '0;
                q_reg      <= '0;
                if (cmd.is_div) begin
                    n_reg   <= op_a[127] ? 128'(-op_a) : 128'(op_a);
                    d_reg   <= op_b[127] ? 128'(-op_b) : 128'(op_b);
                    neg_reg <= op_a[127] ^ op_b[127];
                end else begin
                    amag_reg <= op_a[63] ? (64'd0 - op_a[63:0]) : op_a[63:0];
                    bmag_reg <= op_b[63] ? (64'd0 - op_b[63:0]) : op_b[63:0];
                    neg_reg  <= op_a[63] ^ op_b[63];
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 8'd1;
                if (is_div_reg) begin
                    if (cnt_reg == 8'd128) begin
                        quot_reg <= sat64(neg_reg ? -wide_t'(q_reg) : wide_t'(q_reg));
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        n_reg <= {n_reg[126:0], 1'b0};
                        r_reg <= fits ? (rsh - d_reg) : rsh;
                        q_reg <= {q_reg[126:0], fits};
                    end
                end else begin
                    // partial product registered, accumulated in the following cycle
                    if (cnt_reg < 8'd4) begin
                        pp_reg <= 64'(a_half) * 64'(b_half);
                        sh_reg <= 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                    end
                    if (cnt_reg != 8'd0 && cnt_reg < 8'd5) begin
                        acc_reg <= acc_reg + (128'(pp_reg) << {sh_reg, 5'd0});
                    end
                    if (cnt_reg == 8'd5) begin
                        prod_reg <= neg_reg ? -wide_t'(acc_reg) : wide_t'(acc_reg);
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = prod_reg;
    assign quot      = quot_reg;

    `RLF_ASSERT_IMP(a_md_start_idle, cmd.start, !busy_reg, "muldiv started while busy")
    `RLF_ASSERT_NEXT(a_md_done_idle, done_reg, !busy_reg || cmd.start, "muldiv busy after done")

endmodule

### rtl/core/running_line_fit.sv
// Running least-squares line fit: top level with sums, sequencer and output register.
// Each item is one action. Add folds the point into the count and the sums of x, y,
// x*y and x*x (two products on one small multiplier), then, with two or more points,
// solves slope and intercept by Cramer's rule on a shared multiply/divide unit: six
// 64x64 products (four 32x32 partial products each) and two restoring 128-bit divides
// that give one quotient bit per cycle. Evaluate takes one product; clear and the
// unused code do not use the unit. The input is not ready while an item is being
// worked; a finished result waits in the output register while the next item is
// taken. Points past MAX_POINTS-1 leave the sums alone but still re-solve; a zero
// determinant zeroes the fit and raises the flag.
`include "assert_macros.svh"

module running_line_fit #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0], point_x[25:2], point_y[49:26], zero pad
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slope[63:0], intercept[127:64], y_value[191:128], point_count[199:192],
    // no_unique_fit[200], zero pad
    output logic [207:0] m_tdata
);
    import rlf_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS);
    localparam int SX_W  = COORD_BITS + CNT_W;
    localparam int SXY_W = 2 * COORD_BITS + CNT_W;
    localparam int PR_W  = 2 * COORD_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PXY   = 3'd1;
    localparam logic [2:0] S_PXX   = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // solve and evaluate steps on the shared unit
    localparam logic [3:0] ST_NSXX = 4'd0;
    localparam logic [3:0] ST_DEN  = 4'd1;
    localparam logic [3:0] ST_NSXY = 4'd2;
    localparam logic [3:0] ST_NS   = 4'd3;
    localparam logic [3:0] ST_SXXY = 4'd4;
    localparam logic [3:0] ST_NI   = 4'd5;
    localparam logic [3:0] ST_SLP  = 4'd6;
    localparam logic [3:0] ST_ICP  = 4'd7;
    localparam logic [3:0] ST_EVAL = 4'd8;

    logic [2:0] state_reg;
    logic [3:0] step_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic signed [PR_W-1:0]       sprod_reg;

    logic [CNT_W-1:0]         count_reg;
    logic signed [SX_W-1:0]   sx_reg, sy_reg;
    logic signed [SXY_W-1:0]  sxy_reg, sxx_reg;
    q64_t  slope_reg, icpt_reg, yv_reg;
    logic  flag_reg;
    wide_t t0_reg, den_reg, ns_reg, ni_reg;

    logic         m_valid_reg;
    logic [207:0] m_data_reg;
    logic         out_load;

    md_cmd_t  md_cmd;
    md_stat_t md_stat;
    wide_t    md_a, md_b, md_prod, diff;
    q64_t     md_quot;
    wide_t    n_w, sx_w, sy_w, sxy_w, sxx_w;
    logic [15:0] cnt16;
    logic signed [COORD_BITS-1:0] in_x, in_y;

    assign in_x  = s_tdata[2 +: COORD_BITS];
    assign in_y  = s_tdata[26 +: COORD_BITS];
    assign n_w   = wide_t'(count_reg);
    assign sx_w  = wide_t'(sx_reg);
    assign sy_w  = wide_t'(sy_reg);
    assign sxy_w = wide_t'(sxy_reg);
    assign sxx_w = wide_t'(sxx_reg);
    assign diff  = t0_reg - md_prod;
    assign cnt16 = 16'(count_reg);

    assign s_tready = (state_reg == S_IDLE);

    // result moves into the output register when it is empty or being drained
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    // operand select for the current step
    always_comb begin
        md_a = sxx_w;
        md_b = n_w;
        md_cmd.is_div = 1'b0;
        unique case (step_reg)
            ST_NSXX: begin md_a = sxx_w; md_b = n_w;  end
            ST_DEN:  begin md_a = sx_w;  md_b = sx_w; end
            ST_NSXY: begin md_a = sxy_w; md_b = n_w;  end
            ST_NS:   begin md_a = sx_w;  md_b = sy_w; end
            ST_SXXY: begin md_a = sxx_w; md_b = sy_w; end
            ST_NI:   begin md_a = sxy_w; md_b = sx_w; end
            ST_SLP: begin
                md_a = ns_reg <<< 32;
                md_b = den_reg;
                md_cmd.is_div = 1'b1;
            end
            ST_ICP: begin
                md_a = ni_reg <<< 16;
                md_b = den_reg;
                md_cmd.is_div = 1'b1;
            end
            ST_EVAL: begin md_a = wide_t'(slope_reg); md_b = wide_t'(x_reg); end
            default: begin md_a = sxx_w; md_b = n_w; end
        endcase
        md_cmd.start = (state_reg == S_ISSUE);
    end

    rlf_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (md_cmd),
        .op_a    (md_a),
        .op_b    (md_b),
        .stat    (md_stat),
        .prod    (md_prod),
        .quot    (md_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= ST_NSXX;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sxy_reg     <= '0;
            sxx_reg     <= '0;
            slope_reg   <= '0;
            icpt_reg    <= '0;
            flag_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg   <= in_x;
                        y_reg   <= in_y;
                        yv_reg  <= '0;
                        case (s_tdata[1:0])
                            ACT_ADD: begin
                                step_reg <= ST_NSXX;
                                if (32'(count_reg) < MAX_POINTS - 1) begin
                                    state_reg <= S_PXY;
                                end else begin
                                    state_reg <= S_ISSUE;
                                end
                            end
                            ACT_EVAL: begin
                                step_reg  <= ST_EVAL;
                                state_reg <= S_ISSUE;
                            end
                            ACT_CLEAR: begin
                                step_reg  <= ST_NSXX;
                                count_reg <= '0;
                                sx_reg    <= '0;
                                sy_reg    <= '0;
                                sxy_reg   <= '0;
                                sxx_reg   <= '0;
                                state_reg <= S_DONE;
                            end
                            default: begin
                                step_reg  <= ST_NSXX;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_PXY: begin
                    sprod_reg <= x_reg * y_reg;
                    state_reg <= S_PXX;
                end
                S_PXX: begin
                    sxy_reg   <= sxy_reg + SXY_W'(sprod_reg);
                    sprod_reg <= x_reg * x_reg;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    sxx_reg   <= sxx_reg + SXY_W'(sprod_reg);
                    sx_reg    <= sx_reg + SX_W'(x_reg);
                    sy_reg    <= sy_reg + SX_W'(y_reg);
                    count_reg <= count_reg + CNT_W'(1);
                    // solve once two points are in
                    state_reg <= (count_reg != '0) ? S_ISSUE : S_DONE;
                end
                S_ISSUE: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (md_stat.done) begin
                        step_reg <= step_reg + 4'd1;
                        case (step_reg)
                            ST_DEN: begin
                                den_reg <= diff;
                                if (diff == '0) begin
                                    slope_reg <= '0;
                                    icpt_reg  <= '0;
                                    flag_reg  <= 1'b1;
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_ISSUE;
                                end
                            end
                            ST_NS: begin
                                ns_reg    <= diff;
                                state_reg <= S_ISSUE;
                            end
                            ST_NI: begin
                                ni_reg    <= diff;
                                state_reg <= S_ISSUE;
                            end
                            ST_SLP: begin
                                slope_reg <= md_quot;
                                state_reg <= S_ISSUE;
                            end
                            ST_ICP: begin
                                icpt_reg  <= md_quot;
                                flag_reg  <= 1'b0;
                                state_reg <= S_DONE;
                            end
                            ST_EVAL: begin
                                yv_reg <= sat64((md_prod + (wide_t'(icpt_reg) <<< 16)) >>> 16);
                                state_reg <= S_DONE;
                            end
                            default: begin
                                t0_reg    <= md_prod;
                                state_reg <= S_ISSUE;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        m_data_reg  <= {7'd0, flag_reg, cnt16[7:0], yv_reg, icpt_reg,
                                        slope_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `RLF_ASSERT_IMP(a_ready_unit_idle, s_tready, !md_stat.busy, "ready while unit busy")
    `RLF_ASSERT_IMP(a_done_in_wait, md_stat.done, state_reg == S_WAIT, "unit done outside wait")
    `RLF_ASSERT_IMP(a_issue_unit_free, state_reg == S_ISSUE, !md_stat.busy,
        "issue while unit busy")

endmodule

### test/tb_running_line_fit.sv
// Testbench for running_line_fit: random and directed actions checked against a line fit model.
`timescale 1ns / 100ps

module tb_running_line_fit;
    import rlf_pkg::*;

    localparam int MAXP = 256;
    localparam int N_RANDOM = 1130;
    localparam longint CYCLE_LIMIT = 2000000;

    // packed from the top bit down, so slope lands in the low bits
    typedef struct packed {
        logic        no_unique_fit;
        logic [7:0]  point_count;
        logic [63:0] y_value;
        logic [63:0] intercept;
        logic [63:0] slope;
    } fit_report_t;

    // Line fit model plus queue of pending reports.
    class fit_scoreboard;
        int unsigned n_pts;
        logic signed [127:0] sx, sy, sxy, sxx;
        logic signed [63:0] slope_q, icpt_q;
        logic degen;
        fit_report_t pending[$];
        int errors;

        function new();
            clear_sums();
            slope_q = 0; icpt_q = 0; degen = 0; errors = 0;
        endfunction

        function void clear_sums();
            n_pts = 0; sx = 0; sy = 0; sxy = 0; sxx = 0;
        endfunction

        // Truncating divide, then clamp.
        function logic signed [63:0] div_sat(logic signed [127:0] num,
                                             logic signed [127:0] den);
            logic [127:0] an, ad, q;
            an = num[127] ? -num : num;
            ad = den[127] ? -den : den;
            q = an / ad;
            if (num[127] != den[127]) q = -q;
            return sat64(q);
        endfunction

        function void solve_fit();
            logic signed [127:0] n, d, ns, ni;
            n = n_pts;
            d = sxx * n - sx * sx;
            if (d == 0) begin
                slope_q = 0; icpt_q = 0; degen = 1;
            end else begin
                ns = sxy * n - sx * sy;
                ni = sxx * sy - sxy * sx;
                slope_q = div_sat(ns <<< 32, d);
                icpt_q = div_sat(ni <<< 16, d);
                degen = 0;
            end
        endfunction

        function void note_item(logic [1:0] act, logic signed [23:0] px,
                                logic signed [23:0] py);
            fit_report_t r;
            logic signed [127:0] acc, x, y;
            logic signed [63:0] yv;
            x = px; y = py; yv = 0;
            case (act)
                ACT_ADD: begin
                    if (n_pts < MAXP - 1) begin
                        sx += x; sy += y; sxy += x * y; sxx += x * x;
                        n_pts++;
                    end
                    if (n_pts > 1) solve_fit();
                end
                ACT_EVAL: begin
                    acc = 128'(slope_q) * x + (128'(icpt_q) <<< 16);
                    yv = sat64(acc >>> 16);
                end
                ACT_CLEAR: clear_sums();
                default: ;
            endcase
            r.slope = slope_q; r.intercept = icpt_q; r.y_value = yv;
            r.point_count = n_pts[7:0]; r.no_unique_fit = degen;
            pending.push_back(r);
        endfunction

        function void check_report(fit_report_t got);
            fit_report_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp slope %h icpt %h y %h n %0d f %b",
                             e.slope, e.intercept, e.y_value, e.point_count,
                             e.no_unique_fit);
                    $display("          got slope %h icpt %h y %h n %0d f %b",
                             got.slope, got.intercept, got.y_value, got.point_count,
                             got.no_unique_fit);
                end
            end
        endfunction
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [55:0] s_tdata = '0;
    logic m_tvalid, m_tready = 0;
    logic [207:0] m_tdata;
    fit_scoreboard sb;
    longint cycles = 0;
    bit stim_done = 0;
    bit hold_off = 0;

    always #4 aclk = ~aclk;

    running_line_fit dut (.*);

    // Drive one item, wait for acceptance, then a random gap.
    task automatic send_item(logic [1:0] act, logic signed [23:0] px, logic signed [23:0] py);
        int gap;
        s_tdata <= {6'd0, py, px, act};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(act, px, py);
        @(negedge aclk);
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic logic signed [23:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(0, 15) - 8);
            default: return 24'($urandom);
        endcase
    endfunction

    // Stimulus.
    initial begin
        int pick;
        logic [1:0] act;
        sb = new();
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: eval at reset, one point, degenerate, extremes, full group, code 3
        send_item(ACT_EVAL, 24'sh7FFFFF, 24'sd0);
        send_item(ACT_ADD, 24'sd5, 24'sd7);
        send_item(ACT_ADD, 24'sd5, -24'sd3);
        send_item(ACT_EVAL, 24'sh800000, 24'sd0);
        send_item(ACT_ADD, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(ACT_ADD, 24'sh800000, 24'sh800000);
        send_item(ACT_EVAL, 24'sh7FFFFF, 24'sd0);
        send_item(2'd3, 24'sd1, 24'sd1);
        send_item(ACT_CLEAR, 24'sd0, 24'sd0);
        send_item(ACT_ADD, 24'sd0, 24'sh7FFFFF);
        send_item(ACT_ADD, 24'sd1, 24'sh800000);
        send_item(ACT_EVAL, 24'sh800000, 24'sh7FFFFF);
        send_item(ACT_CLEAR, 24'sd0, 24'sd0);
        for (int i = 0; i < MAXP + 2; i++)
            send_item(ACT_ADD, 24'(i % 7), 24'($urandom_range(0, 100)));
        send_item(ACT_EVAL, 24'sd3, 24'sd0);
        send_item(ACT_CLEAR, 24'sd0, 24'sd0);
        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) act = ACT_ADD;
            else if (pick < 88) act = ACT_EVAL;
            else if (pick < 96) act = ACT_CLEAR;
            else act = 2'd3;
            send_item(act, rnd_coord(), rnd_coord());
        end
        s_tvalid <= 0;
        stim_done = 1;
    end

    // Result side: random stalls, one long hold-off early on.
    initial begin
        @(posedge aresetn);
        repeat (400) @(negedge aclk);
        hold_off = 1;
        repeat (1500) @(negedge aclk);
        hold_off = 0;
    end

    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
            end else begin
                stall = $urandom_range(0, 3);
                if (stall > 0 && !m_tready) begin
                    repeat (stall - 1) @(negedge aclk);
                end
                m_tready <= (stall == 0) || !m_tready || ($urandom_range(0, 1) == 1);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(fit_report_t'(m_tdata[200:0]));
    end

    // End of run and watchdog.
    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
        end else if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT + 1000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/rlf_pkg.sv
rtl/core/rlf_muldiv.sv
rtl/core/running_line_fit.sv
test/tb_running_line_fit.sv
